[hw/rtl/t8cpu_pkg.sv]
package t8cpu_pkg;

  // memory geometry
  localparam int unsigned MemDepth = 256;
  localparam int unsigned AddrW    = $clog2(MemDepth);
  localparam int unsigned DataW    = 8;

  typedef logic [AddrW-1:0] addr_t;
  typedef logic [DataW-1:0] byte_t;

  // architectural registers mapped into the low bytes of memory
  localparam addr_t AccLoc  = addr_t'(0);
  localparam addr_t FlagLoc = addr_t'(1);
  localparam addr_t SpLoc   = addr_t'(2);
  localparam addr_t PcLoc   = addr_t'(3);

  // reset image
  localparam byte_t PcResetVal    = byte_t'(8'h10);
  localparam byte_t SpResetVal    = byte_t'(8'hff);
  localparam addr_t BootTableBase = addr_t'(8);
  localparam addr_t BootTableLast = addr_t'(15);
  localparam addr_t ClearLastLow  = addr_t'(8'h0f);
  localparam addr_t ClearLastAll  = addr_t'(MemDepth - 1);

  // transaction modes
  typedef enum logic [1:0] {
    ModeExec  = 2'd0,
    ModeRead  = 2'd1,
    ModeWrite = 2'd2,
    ModeReset = 2'd3
  } mode_e;

  // instruction opcodes (high nibble)
  typedef enum logic [3:0] {
    OpLoadc = 4'd0,
    OpPush  = 4'd1,
    OpPop   = 4'd2,
    OpInc   = 4'd3,
    OpDec   = 4'd4,
    OpAdd   = 4'd5,
    OpSub   = 4'd6,
    OpAnd   = 4'd7,
    OpOr    = 4'd8,
    OpNot   = 4'd9,
    OpSeta  = 4'd10,
    OpPuta  = 4'd11,
    OpCall  = 4'd12
  } op_e;

  // value held by a memory byte after a reset
  function automatic byte_t reset_value(addr_t a);
    byte_t v;
    v = '0;
    if (a == PcLoc) begin
      v = PcResetVal;
    end else if (a == SpLoc) begin
      v = SpResetVal;
    end else if ((a >= BootTableBase) && (a <= BootTableLast)) begin
      v = byte_t'(a - BootTableBase);
    end
    return v;
  endfunction

endpackage

[hw/rtl/tiny_8bit_memory_mapped_cpu_core_unit.sv]
// Steps from accept to result valid: write: done; read: read state; execute: decode, then
// inc/dec/add/sub/and/or/not/seta: pointer, operand, store; push: same, then SP decrement;
// pop: SP increment, operand, store; puta: operand, store; loadc: load, PC increment;
// other opcodes end after decode. One transaction at a time; the next is taken once the
// result is registered. A reset transaction rewrites the low 16 bytes, or all bytes with
// clear_all_i. After rst_ni the core sweeps all 256 bytes before it accepts input.
module tiny_8bit_memory_mapped_cpu_core_unit import t8cpu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] mode_i,
  input  logic [7:0] addr_i,
  input  logic [7:0] data_i,
  input  logic       clear_all_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] read_data_o,
  output logic [7:0] pc_value_o,
  output logic [7:0] flag_value_o
);

  typedef enum logic [11:0] {
    StIdle   = 12'b000000000001,
    StDecode = 12'b000000000010,
    StPtr    = 12'b000000000100,
    StOpnd   = 12'b000000001000,
    StStore  = 12'b000000010000,
    StSpDec  = 12'b000000100000,
    StSpInc  = 12'b000001000000,
    StLoadc  = 12'b000010000000,
    StPcInc  = 12'b000100000000,
    StRead   = 12'b001000000000,
    StClear  = 12'b010000000000,
    StDone   = 12'b100000000000
  } state_e;

  state_e state_q, state_d;

  // memory port
  logic  ram_we;
  addr_t ram_waddr;
  byte_t ram_wdata;
  addr_t ram_raddr;
  byte_t ram_rdata;

  // shadow copies of the memory-mapped registers
  byte_t pc_q, sp_q, acc_q, flag_q;

  // instruction and datapath registers
  op_e        op_q;
  logic [3:0] idx_q;
  op_e        op_dec;
  byte_t      res_q;
  byte_t      rdbuf_q;

  // clearing sweep
  addr_t clr_cnt_q, clr_last_q;
  logic  clr_item_q;

  // result register
  logic  out_valid_q;
  byte_t out_rd_q, out_pc_q, out_flag_q;

  // shared alu
  byte_t      alu_a, alu_b, alu_res;
  logic       alu_sub, alu_flag;
  logic [8:0] alu_sum;

  t8cpu_ram #(
    .Width(DataW),
    .Depth(MemDepth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign op_dec = op_e'(ram_rdata[7:4]);

  // alu: one 9-bit adder plus logic ops, flag per instruction class
  always_comb begin
    alu_a   = (op_q == OpPuta) ? acc_q : ram_rdata;
    alu_b   = (op_q inside {OpInc, OpDec}) ? byte_t'(1) : acc_q;
    alu_sub = op_q inside {OpDec, OpSub};
    alu_sum = {1'b0, alu_a} + (alu_sub ? ~{1'b0, alu_b} : {1'b0, alu_b})
              + {8'b0, alu_sub};
    case (op_q)
      OpInc, OpDec, OpAdd, OpSub: begin
        alu_res  = alu_sum[7:0];
        alu_flag = alu_sum[8];
      end
      OpAnd: begin
        alu_res  = alu_a & alu_b;
        alu_flag = 1'b0;
      end
      OpOr: begin
        alu_res  = alu_a | alu_b;
        alu_flag = 1'b0;
      end
      OpNot: begin
        alu_res  = ~alu_a;
        alu_flag = (~alu_a == '0);
      end
      default: begin
        alu_res  = alu_a;
        alu_flag = (alu_a == '0);
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    ram_we    = 1'b0;
    ram_waddr = PcLoc;
    ram_wdata = '0;
    ram_raddr = pc_q;
    case (state_q)
      StIdle: begin
        if (mode_e'(mode_i) == ModeRead) begin
          ram_raddr = addr_i;
        end
        if (in_valid_i) begin
          case (mode_e'(mode_i))
            ModeExec:  state_d = StDecode;
            ModeRead:  state_d = StRead;
            ModeWrite: begin
              ram_we    = 1'b1;
              ram_waddr = addr_i;
              ram_wdata = data_i;
              state_d   = StDone;
            end
            default:   state_d = StClear;
          endcase
        end
      end
      StDecode: begin
        ram_we    = 1'b1;
        ram_waddr = PcLoc;
        ram_wdata = pc_q + 8'd1;
        ram_raddr = (op_dec == OpLoadc) ? pc_q + 8'd1 : addr_t'(ram_rdata[3:0]);
        case (op_dec)
          OpLoadc: state_d = StLoadc;
          OpPop:   state_d = StSpInc;
          OpPuta:  state_d = StOpnd;
          OpPush, OpInc, OpDec, OpAdd, OpSub, OpAnd, OpOr, OpNot, OpSeta:
                   state_d = StPtr;
          default: state_d = StDone;
        endcase
      end
      StPtr: begin
        ram_raddr = ram_rdata;
        state_d   = StOpnd;
      end
      StOpnd: begin
        ram_we    = 1'b1;
        ram_waddr = FlagLoc;
        ram_wdata = byte_t'(alu_flag);
        ram_raddr = addr_t'(idx_q);
        state_d   = StStore;
      end
      StStore: begin
        ram_we    = 1'b1;
        ram_wdata = res_q;
        case (op_q)
          OpPush:                            ram_waddr = sp_q;
          OpAdd, OpSub, OpAnd, OpOr, OpSeta: ram_waddr = AccLoc;
          default:                           ram_waddr = ram_rdata;
        endcase
        state_d = (op_q == OpPush) ? StSpDec : StDone;
      end
      StSpDec: begin
        ram_we    = 1'b1;
        ram_waddr = SpLoc;
        ram_wdata = sp_q - 8'd1;
        state_d   = StDone;
      end
      StSpInc: begin
        ram_we    = 1'b1;
        ram_waddr = SpLoc;
        ram_wdata = sp_q + 8'd1;
        ram_raddr = sp_q + 8'd1;
        state_d   = StOpnd;
      end
      StLoadc: begin
        ram_we    = 1'b1;
        ram_waddr = addr_t'(idx_q);
        ram_wdata = ram_rdata;
        state_d   = StPcInc;
      end
      StPcInc: begin
        ram_we    = 1'b1;
        ram_waddr = PcLoc;
        ram_wdata = pc_q + 8'd1;
        state_d   = StDone;
      end
      StRead: begin
        state_d = StDone;
      end
      StClear: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        ram_wdata = reset_value(clr_cnt_q);
        if (clr_cnt_q == clr_last_q) begin
          state_d = clr_item_q ? StDone : StIdle;
        end
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // control state, shadow registers and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_cnt_q   <= '0;
      clr_last_q  <= ClearLastAll;
      clr_item_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pc_q        <= PcResetVal;
      sp_q        <= SpResetVal;
      acc_q       <= '0;
      flag_q      <= '0;
    end else begin
      state_q <= state_d;
      // snoop memory writes into the shadow registers
      if (ram_we) begin
        if (ram_waddr == PcLoc)   pc_q   <= ram_wdata;
        if (ram_waddr == SpLoc)   sp_q   <= ram_wdata;
        if (ram_waddr == AccLoc)  acc_q  <= ram_wdata;
        if (ram_waddr == FlagLoc) flag_q <= ram_wdata;
      end
      if (state_q == StIdle && in_valid_i && mode_e'(mode_i) == ModeReset) begin
        clr_cnt_q  <= '0;
        clr_last_q <= clear_all_i ? ClearLastAll : ClearLastLow;
        clr_item_q <= 1'b1;
      end else if (state_q == StClear) begin
        clr_cnt_q <= clr_cnt_q + addr_t'(1);
      end
      if (state_q == StDone && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == StDecode) begin
      op_q  <= op_dec;
      idx_q <= ram_rdata[3:0];
    end
    if (state_q == StOpnd) begin
      res_q <= alu_res;
    end
    if (state_q == StIdle && in_valid_i) begin
      rdbuf_q <= '0;
    end else if (state_q == StRead) begin
      rdbuf_q <= ram_rdata;
    end
    if (state_q == StDone && (!out_valid_q || out_ready_i)) begin
      out_rd_q   <= rdbuf_q;
      out_pc_q   <= pc_q;
      out_flag_q <= flag_q;
    end
  end

  assign in_ready_o   = (state_q == StIdle);
  assign out_valid_o  = out_valid_q;
  assign read_data_o  = out_rd_q;
  assign pc_value_o   = out_pc_q;
  assign flag_value_o = out_flag_q;

endmodule

[hw/rtl/t8cpu_ram.sv]
module t8cpu_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // one write port, one registered read port, write-first on a collision
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/t8cpu_checker.sv]
module t8cpu_checker import t8cpu_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [1:0] mode_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] read_data_o,
  input logic [7:0] pc_value_o,
  input logic [7:0] flag_value_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_data_o)
      && $stable(pc_value_o) && $stable(flag_value_o))
    else $error("result changed while stalled");

  // one transaction at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while a transaction is in flight");

  // a new result only comes out of a busy cycle
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result appeared while idle");

  // a reset transaction keeps the core busy while it sweeps memory
  a_reset_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (mode_i == ModeReset)
      |=> !in_ready_o ##1 !in_ready_o ##1 !in_ready_o ##1 !in_ready_o)
    else $error("reset transaction finished too early");

endmodule

bind tiny_8bit_memory_mapped_cpu_core_unit t8cpu_checker u_t8cpu_checker (.*);
